// ----- rtl/whtr_pkg.sv -----
package whtr_pkg;

  localparam int MAX_WINDOWS_DEF = 16;
  localparam int COORD_BITS_DEF  = 12;
  localparam int RANK_BITS       = 5;
  localparam int CNT_BITS        = 5;
  localparam int IDXIN_BITS      = 4;
  localparam int ID_BITS         = 5;
  localparam logic [CNT_BITS-1:0] COUNT_RESET = 5'd16;
  localparam logic [RANK_BITS-1:0] RANK_TOP   = 5'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DELIVER
  } state_t;

  // Broadcast to every cell: a slot write and a post-hit rank update.
  typedef struct packed {
    logic                  load;
    logic [IDXIN_BITS-1:0] load_idx;
    logic [RANK_BITS-1:0]  load_rank;
    logic                  upd;
    logic [RANK_BITS-1:0]  best_rank;
  } cmd_t;

  // Scan token passed cell to cell; winner index travels beside it.
  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [RANK_BITS-1:0] rank;
  } tok_t;

endpackage

// ----- rtl/whtr_cell.sv -----
module whtr_cell #(
  parameter int IDX        = 0,
  parameter int IDX_W      = 4,
  parameter int COORD_BITS = whtr_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  whtr_pkg::cmd_t                cmd,
  input  logic [whtr_pkg::CNT_BITS-1:0] act_count,
  input  logic [COORD_BITS-1:0]         ld_left,
  input  logic [COORD_BITS-1:0]         ld_top,
  input  logic [COORD_BITS-1:0]         ld_right,
  input  logic [COORD_BITS-1:0]         ld_bottom,
  input  logic [COORD_BITS-1:0]         px,
  input  logic [COORD_BITS-1:0]         py,
  input  whtr_pkg::tok_t                tok_i,
  input  logic [IDX_W-1:0]              idx_i,
  output whtr_pkg::tok_t                tok_o,
  output logic [IDX_W-1:0]              idx_o
);
  import whtr_pkg::*;

  localparam logic [6:0] IDX_L = 7'(IDX);

  logic [COORD_BITS-1:0] left_r, top_r, right_r, bottom_r;
  logic [RANK_BITS-1:0]  rank_r, rank_nxt;
  tok_t                  tok_r, tok_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  active, sel, hit, take;

  assign active = {2'b00, act_count} > IDX_L;
  assign sel    = cmd.load && ({3'b000, cmd.load_idx} == IDX_L);
  assign hit    = active && px >= left_r && px <= right_r && py >= top_r && py <= bottom_r;
  assign take   = hit && (!tok_i.found || rank_r < tok_i.rank);

  always_comb begin
    tok_nxt = tok_i;
    idx_nxt = idx_i;
    if (take) begin
      tok_nxt.found = 1'b1;
      tok_nxt.rank  = rank_r;
      idx_nxt       = IDX_W'(IDX);
    end
  end

  always_comb begin
    rank_nxt = rank_r;
    if (sel) begin
      rank_nxt = cmd.load_rank;
    end else if (cmd.upd && active) begin
      if (rank_r == cmd.best_rank) begin
        rank_nxt = RANK_TOP;
      end else if (rank_r < cmd.best_rank) begin
        rank_nxt = rank_r + RANK_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.found <= tok_nxt.found;
    tok_r.rank  <= tok_nxt.rank;
    idx_r       <= idx_nxt;
    rank_r      <= rank_nxt;
    if (sel) begin
      left_r   <= ld_left;
      top_r    <= ld_top;
      right_r  <= ld_right;
      bottom_r <= ld_bottom;
    end
  end

  assign tok_o = tok_r;
  assign idx_o = idx_r;

endmodule

// ----- rtl/window_hit_test_raise_core.sv -----
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    op, window_index, left, top, right, bottom,
//                                            point_x, point_y
// out_     output     out_valid / out_ready  hit, window_id
// cfg_     input      cfg_we                 wdata = window_count
//
// A load does not leave the idle state; the next item may follow directly.
// A click walks a token through the row of MAX_WINDOWS cells, one cell per cycle,
// so the result is first captured at the row's end and then moved into the output register.
// The input is held off from click acceptance until the result is moved out; a full
// output register stalls that move, not the rank update.
// Reset (rst_n, synchronous) clears control and sets window_count to 16; slot contents
// stay undefined until loaded.
module window_hit_test_raise_core #(
  parameter int MAX_WINDOWS = whtr_pkg::MAX_WINDOWS_DEF,
  parameter int COORD_BITS  = whtr_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [whtr_pkg::CNT_BITS-1:0]   cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [whtr_pkg::IDXIN_BITS-1:0] in_window_index,
  input  logic [COORD_BITS-1:0]           in_left,
  input  logic [COORD_BITS-1:0]           in_top,
  input  logic [COORD_BITS-1:0]           in_right,
  input  logic [COORD_BITS-1:0]           in_bottom,
  input  logic [COORD_BITS-1:0]           in_point_x,
  input  logic [COORD_BITS-1:0]           in_point_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic [whtr_pkg::ID_BITS-1:0]    out_window_id
);
  import whtr_pkg::*;

  localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

  state_t                state_r, state_nxt;
  logic [CNT_BITS-1:0]   wc_r;
  logic [CNT_BITS-1:0]   act_count;
  logic                  start_r;
  logic [COORD_BITS-1:0] px_r, py_r;
  logic                  res_hit_r;
  logic [ID_BITS-1:0]    res_id_r;
  logic                  out_valid_r, out_hit_r;
  logic [ID_BITS-1:0]    out_id_r;
  logic                  click_acc, capture, deliver;
  cmd_t                  cmd;

  tok_t             tok  [MAX_WINDOWS+1];
  logic [IDX_W-1:0] tidx [MAX_WINDOWS+1];

  assign act_count = ({2'b00, wc_r} > 7'(MAX_WINDOWS)) ? CNT_BITS'(MAX_WINDOWS) : wc_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid && in_op) state_nxt = ST_SCAN;
      ST_SCAN:    if (tok[MAX_WINDOWS].valid) state_nxt = ST_DELIVER;
      ST_DELIVER: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    click_acc = in_ready && in_valid && in_op;
    capture   = (state_r == ST_SCAN) && tok[MAX_WINDOWS].valid;
    deliver   = (state_r == ST_DELIVER) && (!out_valid_r || out_ready);
  end

  always_comb begin
    cmd.load      = in_ready && in_valid && !in_op &&
                    ({1'b0, in_window_index} < act_count);
    cmd.load_idx  = in_window_index;
    cmd.load_rank = act_count - {1'b0, in_window_index};
    cmd.upd       = capture && tok[MAX_WINDOWS].found;
    cmd.best_rank = tok[MAX_WINDOWS].rank;
  end

  assign tok[0]  = '{valid: start_r, found: 1'b0, rank: '0};
  assign tidx[0] = '0;

  for (genvar g = 0; g < MAX_WINDOWS; g++) begin : g_cell
    whtr_cell #(
      .IDX        (g),
      .IDX_W      (IDX_W),
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .act_count (act_count),
      .ld_left   (in_left),
      .ld_top    (in_top),
      .ld_right  (in_right),
      .ld_bottom (in_bottom),
      .px        (px_r),
      .py        (py_r),
      .tok_i     (tok[g]),
      .idx_i     (tidx[g]),
      .tok_o     (tok[g+1]),
      .idx_o     (tidx[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wc_r        <= COUNT_RESET;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= click_acc;
      if (cfg_we) begin
        wc_r <= cfg_wdata;
      end
      if (deliver) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (click_acc) begin
      px_r <= in_point_x;
      py_r <= in_point_y;
    end
    if (capture) begin
      res_hit_r <= tok[MAX_WINDOWS].found;
      res_id_r  <= tok[MAX_WINDOWS].found ?
                   (ID_BITS'(tidx[MAX_WINDOWS]) + ID_BITS'(1)) : '0;
    end
    if (deliver) begin
      out_hit_r <= res_hit_r;
      out_id_r  <= res_id_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_window_id = out_id_r;

  // token leaves the row only while a scan is in flight
  a_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok[MAX_WINDOWS].valid |-> state_r == ST_SCAN)
    else $error("scan token outside scan");

  a_click_scans: assert property (@(posedge clk) disable iff (!rst_n)
    click_acc |=> state_r == ST_SCAN && start_r)
    else $error("click did not start scan");

  a_miss_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_window_id == '0)
    else $error("miss with nonzero id");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == ST_IDLE && !cmd.upd)
    else $error("slot write during scan");

endmodule
